// ===== src/efz_pkg.sv =====
// shared types, constants and helpers for the euler zyx frame transform
// no dependencies
package efz_pkg;

   localparam int COEF_W   = 18;
   localparam int CS_W     = 20;
   localparam int T_W      = 21;
   localparam int CRD_W    = 33;
   localparam int Z_W      = 32;
   localparam int ITERS    = 24;
   localparam int ITER_W   = 5;
   localparam int VEC_W    = 32;
   localparam int ANGLE_W  = 16;
   localparam int IDX_W    = 3;

   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [Z_W-1:0]   PI_Q28      = 32'sd843314857;
   localparam logic signed [Z_W-1:0]   HALF_PI_Q28 = 32'sd421657428;

   localparam logic [1:0] OP_LOCAL_TO_GLOBAL = 2'd0;
   localparam logic [1:0] OP_GLOBAL_TO_LOCAL = 2'd1;
   localparam logic [1:0] OP_DIRECTION       = 2'd2;
   localparam logic [1:0] OP_NONE            = 2'd3;

   localparam logic [IDX_W-1:0] REG_ANGLE_X  = 3'd0;
   localparam logic [IDX_W-1:0] REG_ANGLE_Y  = 3'd1;
   localparam logic [IDX_W-1:0] REG_ANGLE_Z  = 3'd2;
   localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd3;
   localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_OFFSET_Z = 3'd5;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   function automatic logic signed [Z_W-1:0] atan_q28(input logic [ITER_W-1:0] i);
      logic signed [Z_W-1:0] r;
      case (i)
         5'd0:  r = 32'sd210828714;
         5'd1:  r = 32'sd124459457;
         5'd2:  r = 32'sd65760959;
         5'd3:  r = 32'sd33381290;
         5'd4:  r = 32'sd16755422;
         5'd5:  r = 32'sd8385879;
         5'd6:  r = 32'sd4193963;
         5'd7:  r = 32'sd2097109;
         5'd8:  r = 32'sd1048571;
         5'd9:  r = 32'sd524287;
         5'd10: r = 32'sd262144;
         5'd11: r = 32'sd131072;
         5'd12: r = 32'sd65536;
         5'd13: r = 32'sd32768;
         5'd14: r = 32'sd16384;
         5'd15: r = 32'sd8192;
         5'd16: r = 32'sd4096;
         5'd17: r = 32'sd2048;
         5'd18: r = 32'sd1024;
         5'd19: r = 32'sd512;
         5'd20: r = 32'sd256;
         5'd21: r = 32'sd128;
         5'd22: r = 32'sd64;
         5'd23: r = 32'sd32;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   function automatic coef_type clamp_coef(input logic signed [21:0] v);
      coef_type r;
      if (v > 22'sd131071) begin
         r = 18'sd131071;
      end else if (v < -22'sd131072) begin
         r = -18'sd131072;
      end else begin
         r = v[COEF_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/efz_rot_gen.sv =====
// rotation matrix generator: three cordic lanes, then a shared multiplier sequence
// depends on efz_pkg
module efz_rot_gen (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  efz_pkg::angle_type angle_x,
   input  efz_pkg::angle_type angle_y,
   input  efz_pkg::angle_type angle_z,
   output logic               busy,
   output efz_pkg::coef_type  coef [9]
);
   import efz_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_ROT  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [3:0] LAST_MUL = 4'd13;

   logic [2:0]              state_ff, state_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic signed [CRD_W-1:0] x_ff [3], x_in [3];
   logic signed [CRD_W-1:0] y_ff [3], y_in [3];
   logic signed [Z_W-1:0]   z_ff [3], z_in [3];
   logic                    neg_ff [3], neg_in [3];
   logic signed [T_W-1:0]   t_ff [14];
   logic signed [T_W-1:0]   t_in;
   coef_type                coef_ff [9], coef_in [9];
   logic signed [CS_W-1:0]  cosv [3];
   logic signed [CS_W-1:0]  sinv [3];
   logic signed [CS_W-1:0]  op_a, op_b;
   logic signed [2*CS_W-1:0] prod;
   logic signed [2*CS_W-1:0] prod_rnd;
   angle_type               ang [3];
   logic signed [Z_W-1:0]   zl;
   logic signed [CRD_W-1:0] xs, ys, xr, yr;
   logic signed [21:0]      nsy;

   assign ang[0] = angle_x;
   assign ang[1] = angle_y;
   assign ang[2] = angle_z;
   assign busy = (state_ff != ST_IDLE);
   assign coef = coef_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         x_in[l]   = x_ff[l];
         y_in[l]   = y_ff[l];
         z_in[l]   = z_ff[l];
         neg_in[l] = neg_ff[l];
         zl = {ang[l][ANGLE_W-1], ang[l], 15'b0};
         xs = x_ff[l] >>> iter_ff;
         ys = y_ff[l] >>> iter_ff;
         if (state_ff == ST_LOAD) begin
            x_in[l] = CORDIC_GAIN;
            y_in[l] = '0;
            if (zl > HALF_PI_Q28) begin
               z_in[l] = zl - PI_Q28;
               neg_in[l] = 1'b1;
            end else if (zl < -HALF_PI_Q28) begin
               z_in[l] = zl + PI_Q28;
               neg_in[l] = 1'b1;
            end else begin
               z_in[l] = zl;
               neg_in[l] = 1'b0;
            end
         end else if (state_ff == ST_ROT) begin
            if (z_ff[l] >= 0) begin
               x_in[l] = x_ff[l] - ys;
               y_in[l] = y_ff[l] + xs;
               z_in[l] = z_ff[l] - atan_q28(iter_ff);
            end else begin
               x_in[l] = x_ff[l] + ys;
               y_in[l] = y_ff[l] - xs;
               z_in[l] = z_ff[l] + atan_q28(iter_ff);
            end
         end
         // round q2.30 to q1.16 and undo the half-turn fold
         xr = (x_ff[l] + 33'sd8192) >>> 14;
         yr = (y_ff[l] + 33'sd8192) >>> 14;
         cosv[l] = neg_ff[l] ? -xr[CS_W-1:0] : xr[CS_W-1:0];
         sinv[l] = neg_ff[l] ? -yr[CS_W-1:0] : yr[CS_W-1:0];
      end
   end

   // lanes: 0 = x, 1 = y, 2 = z
   always_comb begin
      case (cnt_ff)
         4'd0:  begin op_a = cosv[2];                    op_b = sinv[1]; end
         4'd1:  begin op_a = sinv[2];                    op_b = sinv[1]; end
         4'd2:  begin op_a = cosv[2];                    op_b = cosv[1]; end
         4'd3:  begin op_a = t_ff[0][CS_W-1:0];          op_b = sinv[0]; end
         4'd4:  begin op_a = sinv[2];                    op_b = cosv[0]; end
         4'd5:  begin op_a = t_ff[0][CS_W-1:0];          op_b = cosv[0]; end
         4'd6:  begin op_a = sinv[2];                    op_b = sinv[0]; end
         4'd7:  begin op_a = sinv[2];                    op_b = cosv[1]; end
         4'd8:  begin op_a = t_ff[1][CS_W-1:0];          op_b = sinv[0]; end
         4'd9:  begin op_a = cosv[2];                    op_b = cosv[0]; end
         4'd10: begin op_a = t_ff[1][CS_W-1:0];          op_b = cosv[0]; end
         4'd11: begin op_a = cosv[2];                    op_b = sinv[0]; end
         4'd12: begin op_a = cosv[1];                    op_b = sinv[0]; end
         4'd13: begin op_a = cosv[1];                    op_b = cosv[0]; end
         default: begin op_a = '0;                       op_b = '0;      end
      endcase
      prod     = op_a * op_b;
      prod_rnd = (prod + 40'sd32768) >>> 16;
      t_in     = prod_rnd[T_W-1:0];
   end

   always_comb begin
      nsy = -{{(22-CS_W){sinv[1][CS_W-1]}}, sinv[1]};
      coef_in = coef_ff;
      if (state_ff == ST_FIN) begin
         coef_in[0] = clamp_coef(22'(t_ff[2]));
         coef_in[1] = clamp_coef(22'(t_ff[3]) - 22'(t_ff[4]));
         coef_in[2] = clamp_coef(22'(t_ff[5]) + 22'(t_ff[6]));
         coef_in[3] = clamp_coef(22'(t_ff[7]));
         coef_in[4] = clamp_coef(22'(t_ff[8]) + 22'(t_ff[9]));
         coef_in[5] = clamp_coef(22'(t_ff[10]) - 22'(t_ff[11]));
         coef_in[6] = clamp_coef(nsy);
         coef_in[7] = clamp_coef(22'(t_ff[12]));
         coef_in[8] = clamp_coef(22'(t_ff[13]));
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            iter_in  = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(ITERS - 1)) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_MUL) state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         iter_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      coef_ff <= coef_in;
      if (state_ff == ST_MUL) t_ff[cnt_ff] <= t_in;
   end

endmodule

// ===== src/euler_zyx_frame_transform_unit.sv =====
// throughput one transaction per cycle, unless the rsp output stalls or a matrix rebuild holds req_ready low.
// an angle write rebuilds the matrix (load, 24 cordic steps, 14 shared multiplies and finish),
// during which csr_ready and req_ready are low.
// reset: angle, offset and valid registers clear to zero and the same rebuild runs to form the identity.
// the rsp output register stalls the whole four-stage pipeline when it holds a response and rsp_ready is low.
module euler_zyx_frame_transform_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic signed [31:0]              req_vec_x,
   input  logic signed [31:0]              req_vec_y,
   input  logic signed [31:0]              req_vec_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_res_x,
   output logic signed [31:0]              rsp_res_y,
   output logic signed [31:0]              rsp_res_z,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [efz_pkg::IDX_W-1:0]       csr_index,
   input  logic [31:0]                     csr_data
);
   import efz_pkg::*;

   logic                    gen_busy, gen_start, csr_write, advance;
   coef_type                coef [9];
   angle_type               ang_x_ff, ang_y_ff, ang_z_ff;
   logic signed [VEC_W-1:0] off_ff [3];

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic [1:0]              op1_ff, op2_ff, op3_ff;
   logic signed [VEC_W:0]   vec1_ff [3], vec1_in [3];
   logic signed [50:0]      p2_ff [9], p2_in [9];
   logic signed [36:0]      s3_ff [3], s3_in [3];
   logic signed [VEC_W-1:0] r4_ff [3], r4_in [3];
   logic signed [VEC_W-1:0] vin [3];
   logic signed [52:0]      sum;
   logic signed [37:0]      acc;

   assign csr_ready = !gen_busy;
   assign csr_write = csr_valid && csr_ready;
   assign gen_start = csr_write && (csr_index == REG_ANGLE_X || csr_index == REG_ANGLE_Y
                                    || csr_index == REG_ANGLE_Z);
   assign advance   = !v4_ff || rsp_ready;
   assign req_ready = advance && !gen_busy;

   efz_rot_gen u_rot_gen (
      .clock   (clock),
      .reset   (reset),
      .start   (gen_start),
      .angle_x (ang_x_ff),
      .angle_y (ang_y_ff),
      .angle_z (ang_z_ff),
      .busy    (gen_busy),
      .coef    (coef)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_x_ff <= '0;
         ang_y_ff <= '0;
         ang_z_ff <= '0;
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ANGLE_X:  ang_x_ff  <= csr_data[ANGLE_W-1:0];
            REG_ANGLE_Y:  ang_y_ff  <= csr_data[ANGLE_W-1:0];
            REG_ANGLE_Z:  ang_z_ff  <= csr_data[ANGLE_W-1:0];
            REG_OFFSET_X: off_ff[0] <= csr_data;
            REG_OFFSET_Y: off_ff[1] <= csr_data;
            REG_OFFSET_Z: off_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign vin[0] = req_vec_x;
   assign vin[1] = req_vec_y;
   assign vin[2] = req_vec_z;

   // stage 1: subtract the origin for global points
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (req_operation == OP_GLOBAL_TO_LOCAL)
            vec1_in[i] = 33'(vin[i]) - 33'(off_ff[i]);
         else
            vec1_in[i] = 33'(vin[i]);
      end
   end

   // stage 2: nine products, transposed matrix for every operation other than local to global
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (op1_ff == OP_LOCAL_TO_GLOBAL)
               p2_in[i*3+j] = coef[i*3+j] * vec1_ff[j];
            else
               p2_in[i*3+j] = coef[j*3+i] * vec1_ff[j];
         end
      end
   end

   // stage 3: row sums rounded back to q16.16
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum = 53'(p2_ff[i*3]) + 53'(p2_ff[i*3+1]) + 53'(p2_ff[i*3+2]) + 53'sd32768;
         sum = sum >>> 16;
         s3_in[i] = sum[36:0];
      end
   end

   // stage 4: add origin for local to global, saturate; OP_NONE gives zero
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc = 38'(s3_ff[i]);
         if (op3_ff == OP_LOCAL_TO_GLOBAL) acc = acc + 38'(off_ff[i]);
         if (op3_ff == OP_NONE)
            r4_in[i] = '0;
         else if (acc > 38'sd2147483647)
            r4_in[i] = 32'sh7fffffff;
         else if (acc < -38'sd2147483648)
            r4_in[i] = 32'sh80000000;
         else
            r4_in[i] = acc[VEC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid && req_ready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff  <= req_operation;
         vec1_ff <= vec1_in;
         op2_ff  <= op1_ff;
         p2_ff   <= p2_in;
         op3_ff  <= op2_ff;
         s3_ff   <= s3_in;
         r4_ff   <= r4_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_res_x = r4_ff[0];
   assign rsp_res_y = r4_ff[1];
   assign rsp_res_z = r4_ff[2];

endmodule
